/* rtl/core/three_point_affine_calibrate_map_defines.svh */
// Assertion macros shared by the three-point affine calibration RTL.
`ifndef THREE_POINT_AFFINE_CALIBRATE_MAP_DEFINES_SVH
`define THREE_POINT_AFFINE_CALIBRATE_MAP_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside of reset.
`define TPACM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside of reset.
`define TPACM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/tpacm_pkg.sv */
// Package with the codes and sequencer types of the affine calibration block.
package tpacm_pkg;

  localparam int NUM_POINTS = 3;
  localparam int USER_FRAC_BITS = 16;

  localparam logic [1:0] CMD_STORE = 2'd0;
  localparam logic [1:0] CMD_SOLVE = 2'd1;
  localparam logic [1:0] CMD_MAP   = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_SINGULAR = 2'd1;
  localparam logic [1:0] ST_NOTCAL   = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MAC,
    S_KSTORE,
    S_DET,
    S_DETCHK,
    S_ABS,
    S_DIVGO,
    S_DIVW,
    S_FIN,
    S_MAPPOST
  } state_t;

  typedef enum logic [1:0] {
    M_KPROD,
    M_NUM,
    M_MAP
  } mode_t;

endpackage

/* rtl/core/tpacm_div.sv */
// Bit-serial restoring divider with a round-half-up decision on the remainder.
module tpacm_div #(
  parameter int N_W = 106,
  parameter int D_W = 34
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [N_W-1:0] num,
  input  logic [D_W-1:0] den,
  output logic           done,
  output logic [N_W-1:0] quo,
  output logic           round_up
);
  import tpacm_pkg::*;

  localparam int CW = $clog2(N_W + 1);

  logic           run;
  logic [CW-1:0]  cnt;
  logic [N_W-1:0] nsh;
  logic [D_W-1:0] rem;
  logic [D_W-1:0] den_q;
  logic [D_W:0]   rs;
  logic           fits;

  assign rs = {rem, nsh[N_W-1]};
  assign fits = rs >= {1'b0, den_q};
  // Twice the remainder against the divisor: ties go away from zero.
  assign round_up = {rem, 1'b0} >= {1'b0, den_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CW'(N_W);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      nsh   <= num;
      rem   <= '0;
      quo   <= '0;
      den_q <= den;
    end else if (run) begin
      nsh <= nsh << 1;
      if (fits) begin
        rem <= D_W'(rs - {1'b0, den_q});
        quo <= {quo[N_W-2:0], 1'b1};
      end else begin
        rem <= rs[D_W-1:0];
        quo <= {quo[N_W-2:0], 1'b0};
      end
    end
  end

endmodule

/* rtl/core/three_point_affine_calibrate_map.sv */
// Top level of the three-point affine calibration and pixel mapping block.
//
//   Channel  | Signals                                          | Handshake
//   ---------+--------------------------------------------------+-------------------------
//   command  | command, point_index, pixel_x/y, user_x/y        | start high, busy low
//   result   | mapped_x, mapped_y, status                       | done high for one cycle
//
// A store, an unused command or a map before calibration answers in the cycle after
// acceptance. A map runs per axis a multiply-accumulate pass, a magnitude step and a
// rounding step, then presents the result. A solve forms the pixel cross products, checks
// the determinant, then per coefficient runs a numerator pass and a bit-serial division of
// NW = ACC_W + SH bits. Reset clears the points, coefficients and flag.
// The receiver cannot stall: each result word is presented for exactly one cycle.
`include "three_point_affine_calibrate_map_defines.svh"

module three_point_affine_calibrate_map #(
  parameter int PIXEL_BITS = 12,
  parameter int COEF_FRAC_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            command,
  input  logic [1:0]            point_index,
  input  logic [PIXEL_BITS-1:0] pixel_x,
  input  logic [PIXEL_BITS-1:0] pixel_y,
  input  logic signed [31:0]    user_x,
  input  logic signed [31:0]    user_y,
  output logic                  done,
  output logic signed [31:0]    mapped_x,
  output logic signed [31:0]    mapped_y,
  output logic [1:0]            status
);
  import tpacm_pkg::*;

  // Shift from the numerator scale to the coefficient scale, and back on a map.
  localparam int SH = COEF_FRAC_BITS - USER_FRAC_BITS;
  localparam int HSH = (SH == 0) ? 0 : SH - 1;
  // Pixel cross products and the pixel determinant.
  localparam int K0W = 2 * PIXEL_BITS + 1;
  localparam int DW = 2 * PIXEL_BITS + 3;
  localparam int DMW = 2 * PIXEL_BITS + 2;
  // Shared multiplier: 33-bit signed by KB-bit signed.
  localparam int AW = 33;
  localparam int KB = 2 * PIXEL_BITS + 1;
  localparam int PW = AW + KB;
  // The accumulator holds both the Cramer numerators and the map sums exactly.
  localparam int ACC_W = PIXEL_BITS + 66;
  localparam int NW = ACC_W + SH;

  state_t state, state_next;
  mode_t  mode;

  logic [PIXEL_BITS-1:0] ctrl_pixel_x [NUM_POINTS];
  logic [PIXEL_BITS-1:0] ctrl_pixel_y [NUM_POINTS];
  logic signed [31:0]    ctrl_user_x [NUM_POINTS];
  logic signed [31:0]    ctrl_user_y [NUM_POINTS];
  logic [63:0]           coefficients [6];
  logic                  calibrated;

  logic [2:0]              t;
  logic [2:0]              nterms;
  logic [2:0]              jj;
  logic                    axis;
  logic [PIXEL_BITS-1:0]   px_q;
  logic [PIXEL_BITS-1:0]   py_q;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] term;
  logic signed [ACC_W-1:0] acc_add;
  logic signed [PW-1:0]    prod;
  logic                    prod_neg;
  logic                    prod_sh;
  logic signed [K0W-1:0]   k0 [NUM_POINTS];
  logic signed [DW-1:0]    det;
  logic [DMW-1:0]          d_mag;
  logic                    det_neg;
  logic [ACC_W-1:0]        mag;
  logic                    acc_neg;
  logic signed [31:0]      mx;

  logic signed [AW-1:0] op_a;
  logic signed [KB-1:0] op_b;
  logic                 op_neg;
  logic                 op_sh;
  logic [1:0]           ti;
  logic [1:0]           kr;
  logic signed [KB-1:0] kval;
  logic signed [31:0]   usel;
  logic [2:0]           coef_addr;
  logic [63:0]          coef_rd;
  logic [ACC_W-1:0]     coef_ext;

  logic           div_start;
  logic           div_done;
  logic [NW-1:0]  div_quo;
  logic           div_round;
  logic [NW:0]    qr;
  logic           q_big;
  logic [63:0]    coef_val;

  logic [ACC_W:0] half;
  logic [ACC_W:0] m_rnd;
  logic [ACC_W:0] m_sh;
  logic [31:0]    map_val;

  function automatic logic signed [AW-1:0] pix_a(input logic [PIXEL_BITS-1:0] v);
    return $signed(AW'(v));
  endfunction

  function automatic logic signed [KB-1:0] pix_b(input logic [PIXEL_BITS-1:0] v);
    return $signed(KB'(v));
  endfunction

  function automatic logic signed [KB-1:0] pix_diff(input logic [PIXEL_BITS-1:0] p,
                                                    input logic [PIXEL_BITS-1:0] q);
    logic signed [PIXEL_BITS:0] dv;
    dv = $signed({1'b0, p}) - $signed({1'b0, q});
    return KB'(dv);
  endfunction

  assign busy = (state != S_IDLE);

  // Coefficient store has one read port; the sequencer picks the entry.
  always_comb begin
    case (state)
      S_MAC:     coef_addr = (axis ? 3'd3 : 3'd0) + ((t < 3'd2) ? 3'd1 : 3'd2);
      S_MAPPOST: coef_addr = 3'd3;
      default:   coef_addr = 3'd0;
    endcase
  end
  assign coef_rd = coefficients[coef_addr];
  assign coef_ext = ACC_W'($signed(coef_rd));

  // Operand selection for the shared multiplier.
  assign ti = (t[1:0] == 2'd3) ? 2'd0 : t[1:0];
  assign kr = (jj >= 3'd3) ? 2'(jj - 3'd3) : jj[1:0];
  assign usel = (jj >= 3'd3) ? ctrl_user_y[ti] : ctrl_user_x[ti];

  always_comb begin
    kval = '0;
    case (kr)
      2'd0: kval = KB'(k0[ti]);
      2'd1: begin
        case (ti)
          2'd0:    kval = pix_diff(ctrl_pixel_y[1], ctrl_pixel_y[2]);
          2'd1:    kval = pix_diff(ctrl_pixel_y[2], ctrl_pixel_y[0]);
          default: kval = pix_diff(ctrl_pixel_y[0], ctrl_pixel_y[1]);
        endcase
      end
      default: begin
        case (ti)
          2'd0:    kval = pix_diff(ctrl_pixel_x[2], ctrl_pixel_x[1]);
          2'd1:    kval = pix_diff(ctrl_pixel_x[0], ctrl_pixel_x[2]);
          default: kval = pix_diff(ctrl_pixel_x[1], ctrl_pixel_x[0]);
        endcase
      end
    endcase
  end

  always_comb begin
    op_a = '0;
    op_b = '0;
    op_neg = 1'b0;
    op_sh = 1'b0;
    nterms = 3'd2;
    case (mode)
      M_KPROD: begin
        nterms = 3'd2;
        op_neg = t[0];
        case (jj[1:0])
          2'd0: begin
            op_a = t[0] ? pix_a(ctrl_pixel_x[2]) : pix_a(ctrl_pixel_x[1]);
            op_b = t[0] ? pix_b(ctrl_pixel_y[1]) : pix_b(ctrl_pixel_y[2]);
          end
          2'd1: begin
            op_a = t[0] ? pix_a(ctrl_pixel_x[0]) : pix_a(ctrl_pixel_x[2]);
            op_b = t[0] ? pix_b(ctrl_pixel_y[2]) : pix_b(ctrl_pixel_y[0]);
          end
          default: begin
            op_a = t[0] ? pix_a(ctrl_pixel_x[1]) : pix_a(ctrl_pixel_x[0]);
            op_b = t[0] ? pix_b(ctrl_pixel_y[0]) : pix_b(ctrl_pixel_y[1]);
          end
        endcase
      end
      M_NUM: begin
        nterms = 3'd3;
        op_a = AW'(usel);
        op_b = kval;
      end
      M_MAP: begin
        nterms = 3'd4;
        // Coefficients are split into an unsigned low and a signed high half.
        op_sh = t[0];
        op_a = t[0] ? AW'($signed(coef_rd[63:32])) : $signed({1'b0, coef_rd[31:0]});
        op_b = (t < 3'd2) ? pix_b(px_q) : pix_b(py_q);
      end
      default: begin
        nterms = 3'd2;
      end
    endcase
  end

  assign term = prod_sh ? (ACC_W'(prod) <<< 32) : ACC_W'(prod);
  assign acc_add = prod_neg ? (acc - term) : (acc + term);

  // Coefficient rounding and saturation to signed 64 bits.
  assign qr = {1'b0, div_quo} + (NW + 1)'(div_round);
  assign q_big = |qr[NW:63];
  always_comb begin
    if (acc_neg ^ det_neg) begin
      coef_val = q_big ? 64'h8000_0000_0000_0000 : (~qr[63:0] + 64'd1);
    end else begin
      coef_val = q_big ? 64'h7FFF_FFFF_FFFF_FFFF : qr[63:0];
    end
  end

  // Map rounding to Q16.16 and saturation to signed 32 bits.
  assign half = (SH == 0) ? '0 : ((ACC_W + 1)'(1) << HSH);
  assign m_rnd = {1'b0, mag} + half;
  assign m_sh = m_rnd >> SH;
  always_comb begin
    if (acc_neg) begin
      map_val = (m_sh > (ACC_W + 1)'(64'h8000_0000)) ? 32'h8000_0000
                                                     : (~m_sh[31:0] + 32'd1);
    end else begin
      map_val = (m_sh > (ACC_W + 1)'(64'h7FFF_FFFF)) ? 32'h7FFF_FFFF : m_sh[31:0];
    end
  end

  tpacm_div #(
    .N_W(NW),
    .D_W(DMW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .num      (NW'(mag) << SH),
    .den      (d_mag),
    .done     (div_done),
    .quo      (div_quo),
    .round_up (div_round)
  );

  // Next state and sequencer strobes.
  always_comb begin
    state_next = state;
    div_start = 1'b0;
    case (state)
      S_IDLE: begin
        if (start) begin
          if (command == CMD_SOLVE) begin
            state_next = S_MAC;
          end else if (command == CMD_MAP && calibrated) begin
            state_next = S_MAC;
          end
        end
      end
      S_MAC: begin
        if (t == nterms) begin
          state_next = (mode == M_KPROD) ? S_KSTORE : S_ABS;
        end
      end
      S_KSTORE:  state_next = (jj == 3'd2) ? S_DET : S_MAC;
      S_DET:     state_next = S_DETCHK;
      S_DETCHK:  state_next = (det == '0) ? S_IDLE : S_MAC;
      S_ABS:     state_next = (mode == M_NUM) ? S_DIVGO : S_MAPPOST;
      S_DIVGO: begin
        div_start = 1'b1;
        state_next = S_DIVW;
      end
      S_DIVW:    state_next = div_done ? S_FIN : S_DIVW;
      S_FIN:     state_next = (jj == 3'd5) ? S_IDLE : S_MAC;
      S_MAPPOST: state_next = axis ? S_IDLE : S_MAC;
      default:   state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Control state, stored points, coefficients and the result word.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= M_KPROD;
      calibrated <= 1'b0;
      done       <= 1'b0;
      status     <= ST_OK;
      mapped_x   <= '0;
      mapped_y   <= '0;
      t          <= '0;
      jj         <= '0;
      axis       <= 1'b0;
      for (int i = 0; i < NUM_POINTS; i++) begin
        ctrl_pixel_x[i] <= '0;
        ctrl_pixel_y[i] <= '0;
        ctrl_user_x[i]  <= '0;
        ctrl_user_y[i]  <= '0;
      end
      for (int i = 0; i < 6; i++) begin
        coefficients[i] <= '0;
      end
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            t <= '0;
            jj <= '0;
            axis <= 1'b0;
            case (command)
              CMD_STORE: begin
                if (point_index < 2'(NUM_POINTS)) begin
                  ctrl_pixel_x[point_index] <= pixel_x;
                  ctrl_pixel_y[point_index] <= pixel_y;
                  ctrl_user_x[point_index]  <= user_x;
                  ctrl_user_y[point_index]  <= user_y;
                end
                done <= 1'b1;
                status <= ST_OK;
                mapped_x <= '0;
                mapped_y <= '0;
              end
              CMD_SOLVE: begin
                mode <= M_KPROD;
              end
              CMD_MAP: begin
                mode <= M_MAP;
                if (!calibrated) begin
                  done <= 1'b1;
                  status <= ST_NOTCAL;
                  mapped_x <= '0;
                  mapped_y <= '0;
                end
              end
              default: begin
                done <= 1'b1;
                status <= ST_OK;
                mapped_x <= '0;
                mapped_y <= '0;
              end
            endcase
          end
        end
        S_MAC: begin
          t <= t + 3'd1;
        end
        S_KSTORE: begin
          t <= '0;
          jj <= (jj == 3'd2) ? 3'd0 : jj + 3'd1;
        end
        S_DETCHK: begin
          t <= '0;
          jj <= '0;
          mode <= M_NUM;
          if (det == '0) begin
            calibrated <= 1'b0;
            done <= 1'b1;
            status <= ST_SINGULAR;
            mapped_x <= '0;
            mapped_y <= '0;
          end
        end
        S_FIN: begin
          coefficients[jj] <= coef_val;
          t <= '0;
          jj <= jj + 3'd1;
          if (jj == 3'd5) begin
            calibrated <= 1'b1;
            done <= 1'b1;
            status <= ST_OK;
            mapped_x <= '0;
            mapped_y <= '0;
          end
        end
        S_MAPPOST: begin
          t <= '0;
          axis <= 1'b1;
          if (axis) begin
            done <= 1'b1;
            status <= ST_OK;
            mapped_x <= mx;
            mapped_y <= map_val;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Datapath registers; none of them needs a reset value.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        px_q <= pixel_x;
        py_q <= pixel_y;
        acc <= (command == CMD_MAP) ? coef_ext : '0;
      end
      S_MAC: begin
        if (t < nterms) begin
          prod <= op_a * op_b;
          prod_neg <= op_neg;
          prod_sh <= op_sh;
        end
        if (t != 3'd0) begin
          acc <= acc_add;
        end
      end
      S_KSTORE: begin
        k0[jj[1:0]] <= acc[K0W-1:0];
        acc <= '0;
      end
      S_DET: begin
        det <= DW'(k0[0]) + DW'(k0[1]) + DW'(k0[2]);
      end
      S_DETCHK: begin
        det_neg <= det[DW-1];
        d_mag <= det[DW-1] ? DMW'(-det) : DMW'(det);
        acc <= '0;
      end
      S_ABS: begin
        acc_neg <= acc[ACC_W-1];
        mag <= acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
      end
      S_FIN: begin
        acc <= '0;
      end
      S_MAPPOST: begin
        if (!axis) begin
          mx <= map_val;
          acc <= coef_ext;
        end
      end
      default: begin
      end
    endcase
  end

  // An accepted word either answers in the next cycle or starts a sequence.
  `TPACM_ASSERT_NEXT(a_accept_progress, start && !busy, done || busy,
    "accepted word neither answered nor started a sequence")
  // Every sequence ends with exactly its result word.
  `TPACM_ASSERT_NOW(a_end_has_result, $fell(busy), done,
    "sequence ended without a result word")
  // Only a successful map carries nonzero coordinates.
  `TPACM_ASSERT_NOW(a_zero_unless_ok, done && status != ST_OK,
    mapped_x == '0 && mapped_y == '0, "nonzero coordinates with a failure status")
  // A singular report always leaves the block uncalibrated.
  `TPACM_ASSERT_NOW(a_singular_clears, done && status == ST_SINGULAR, !calibrated,
    "singular solve left the block calibrated")

endmodule
